// ===== rtl/dsfr_pkg.sv =====
// Shared types and constants for the dust sensor frame parser.
package dsfr_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CFG_IDX_W   = 2;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam logic [7:0] HEAD_RESET    = 8'hAA;
    localparam logic [7:0] COMMAND_RESET = 8'hC0;
    localparam logic [7:0] TAIL_RESET    = 8'hAB;

    localparam cfg_idx_t REG_HEAD    = 2'd0;
    localparam cfg_idx_t REG_COMMAND = 2'd1;
    localparam cfg_idx_t REG_TAIL    = 2'd2;

    localparam idx_t SUM_FIRST  = idx_t'(2);
    localparam idx_t SUM_LAST   = idx_t'(7);
    localparam idx_t LAST_POS   = idx_t'(FRAME_BYTES - 1);
    localparam idx_t FULL_COUNT = idx_t'(FRAME_BYTES);

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] command;
        logic [7:0] tail;
    } cfg_t;

    typedef struct packed {
        logic       wr_en;
        idx_t       wr_idx;
        logic [7:0] wr_data;
        logic       shift;
        idx_t       rd_idx;
    } buf_ctl_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b8;
        logic [7:0] b9;
        logic [7:0] rd_data;
    } buf_view_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SUM   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

endpackage

// ===== rtl/dsfr_cfg_regs.sv =====
// Configuration registers for the head, command and tail byte values.
module dsfr_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  dsfr_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]       cfg_data,
    output dsfr_pkg::cfg_t   cfg
);

    dsfr_pkg::cfg_t cfg_reg;
    dsfr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                dsfr_pkg::REG_HEAD:    cfg_next.head    = cfg_data;
                dsfr_pkg::REG_COMMAND: cfg_next.command = cfg_data;
                dsfr_pkg::REG_TAIL:    cfg_next.tail    = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head    <= dsfr_pkg::HEAD_RESET;
            cfg_reg.command <= dsfr_pkg::COMMAND_RESET;
            cfg_reg.tail    <= dsfr_pkg::TAIL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dsfr_frame_buf.sv =====
// Ten-byte frame buffer with one write port, one indexed read and a shift toward the front.
module dsfr_frame_buf (
    input  logic                clk,
    input  dsfr_pkg::buf_ctl_t  ctl,
    output dsfr_pkg::buf_view_t view
);

    logic [7:0] store_reg [dsfr_pkg::FRAME_BYTES];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            if (ctl.wr_idx <= dsfr_pkg::LAST_POS)
            begin
                store_reg[ctl.wr_idx] <= ctl.wr_data;
            end
        end
        else if (ctl.shift)
        begin
            for (int i = 0; i < dsfr_pkg::FRAME_BYTES - 1; i++)
            begin
                store_reg[i] <= store_reg[i + 1];
            end
        end
    end

    always_comb
    begin
        view.b0      = store_reg[0];
        view.b1      = store_reg[1];
        view.b2      = store_reg[2];
        view.b3      = store_reg[3];
        view.b4      = store_reg[4];
        view.b5      = store_reg[5];
        view.b8      = store_reg[8];
        view.b9      = store_reg[9];
        view.rd_data = (ctl.rd_idx <= dsfr_pkg::LAST_POS) ? store_reg[ctl.rd_idx] : 8'h00;
    end

endmodule

// ===== rtl/dsfr_ctrl.sv =====
// Sequencer with the shared checksum adder, frame checks, re-anchor scan and output register.
module dsfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  dsfr_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                sample_valid,
    output logic [15:0]         pm25_tenths,
    output logic [15:0]         pm10_tenths,
    output dsfr_pkg::buf_ctl_t  ctl,
    input  dsfr_pkg::buf_view_t view
);

    dsfr_pkg::state_t state_reg, state_next;
    dsfr_pkg::idx_t   fill_reg, fill_next;
    dsfr_pkg::idx_t   cnt_reg, cnt_next;
    dsfr_pkg::idx_t   idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic             sv_reg, sv_next;
    logic [15:0]      pm25_reg, pm25_next;
    logic [15:0]      pm10_reg, pm10_next;
    logic             in_fire;
    logic             out_take;
    logic             frame_ok;
    logic             cand_ok;
    dsfr_pkg::idx_t   remain;

    assign in_stall = (state_reg != dsfr_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    assign frame_ok = (view.b0 == cfg.head) && (view.b1 == cfg.command)
                   && (view.b9 == cfg.tail) && (sum_reg == view.b8);
    assign remain   = cnt_reg - dsfr_pkg::idx_t'(1);
    assign cand_ok  = (view.b1 == cfg.head)
                   && ((remain == dsfr_pkg::idx_t'(1)) || (view.b2 == cfg.command));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        sv_next        = sv_reg;
        pm25_next      = pm25_reg;
        pm10_next      = pm10_reg;
        ctl.wr_en      = 1'b0;
        ctl.wr_idx     = fill_reg;
        ctl.wr_data    = rx_byte;
        ctl.shift      = 1'b0;
        ctl.rd_idx     = idx_reg;

        case (state_reg)
            dsfr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (fill_reg == '0 ||
                        (fill_reg == dsfr_pkg::idx_t'(1) && rx_byte != cfg.command))
                    begin
                        ctl.wr_idx = '0;
                        ctl.wr_en  = (rx_byte == cfg.head);
                        fill_next  = (rx_byte == cfg.head) ? dsfr_pkg::idx_t'(1) : '0;
                        out_valid_next = 1'b1;
                        sv_next        = 1'b0;
                        pm25_next      = '0;
                        pm10_next      = '0;
                    end
                    else
                    begin
                        ctl.wr_en = 1'b1;
                        if (fill_reg == dsfr_pkg::LAST_POS)
                        begin
                            state_next = dsfr_pkg::ST_SUM;
                            idx_next   = dsfr_pkg::SUM_FIRST;
                            sum_next   = '0;
                        end
                        else
                        begin
                            fill_next      = fill_reg + dsfr_pkg::idx_t'(1);
                            out_valid_next = 1'b1;
                            sv_next        = 1'b0;
                            pm25_next      = '0;
                            pm10_next      = '0;
                        end
                    end
                end
            end
            dsfr_pkg::ST_SUM:
            begin
                sum_next = sum_reg + view.rd_data;
                idx_next = idx_reg + dsfr_pkg::idx_t'(1);
                if (idx_reg == dsfr_pkg::SUM_LAST)
                begin
                    state_next = dsfr_pkg::ST_CHECK;
                end
            end
            dsfr_pkg::ST_CHECK:
            begin
                if (frame_ok)
                begin
                    fill_next      = '0;
                    state_next     = dsfr_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    sv_next        = 1'b1;
                    pm25_next      = {view.b3, view.b2};
                    pm10_next      = {view.b5, view.b4};
                end
                else
                begin
                    cnt_next   = dsfr_pkg::FULL_COUNT;
                    state_next = dsfr_pkg::ST_SCAN;
                end
            end
            dsfr_pkg::ST_SCAN:
            begin
                if (remain == '0 || cand_ok)
                begin
                    ctl.shift      = cand_ok;
                    fill_next      = (remain == '0) ? '0 : remain;
                    state_next     = dsfr_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    sv_next        = 1'b0;
                    pm25_next      = '0;
                    pm10_next      = '0;
                end
                else
                begin
                    ctl.shift = 1'b1;
                    cnt_next  = remain;
                end
            end
            default:
            begin
                state_next = dsfr_pkg::ST_IDLE;
                fill_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsfr_pkg::ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        sv_reg   <= sv_next;
        pm25_reg <= pm25_next;
        pm10_reg <= pm10_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample_valid = sv_reg;
    assign pm25_tenths  = pm25_reg;
    assign pm10_tenths  = pm10_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= dsfr_pkg::LAST_POS)
        else $error("fill count reached a full frame between beats");

    a_sum_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsfr_pkg::ST_SUM && idx_reg == dsfr_pkg::SUM_LAST)
        |=> state_reg == dsfr_pkg::ST_CHECK)
        else $error("checksum pass did not end in the frame check");

    a_valid_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sv_reg) |-> fill_reg == '0)
        else $error("buffer not empty after a valid report");

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsfr_pkg::ST_SCAN |-> cnt_reg != '0)
        else $error("re-anchor scan ran with no bytes left");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !sv_reg) |-> (pm25_reg == '0 && pm10_reg == '0))
        else $error("nonzero readings on an invalid result");

endmodule

// ===== rtl/dust_sensor_frame_resync_parser.sv =====
// Top level of the dust sensor frame parser with resynchronization.
// Each accepted byte gives exactly one result beat. The tenth byte of a report is
// written, summed by the shared 8-bit checksum adder over positions 2 to 7 and
// then put through one frame check. When the report is not valid, the re-anchor scan
// tests one position per cycle while it shifts the buffer by one byte, and gives up
// when no later head qualifies. The input is stalled while a report is checked or
// scanned and while a finished result waits on a stalled output. The frame
// buffer is not cleared at reset; only bytes already received are ever read.
module dust_sensor_frame_resync_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  dsfr_pkg::cfg_idx_t   cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 sample_valid,
    output logic [15:0]          pm25_tenths,
    output logic [15:0]          pm10_tenths
);

    dsfr_pkg::cfg_t      cfg;
    dsfr_pkg::buf_ctl_t  ctl;
    dsfr_pkg::buf_view_t view;

    dsfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsfr_frame_buf u_buf (
        .clk  (clk),
        .ctl  (ctl),
        .view (view)
    );

    dsfr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_valid (sample_valid),
        .pm25_tenths  (pm25_tenths),
        .pm10_tenths  (pm10_tenths),
        .ctl          (ctl),
        .view         (view)
    );

endmodule
